// File: rtl/mlfr_pkg.sv
// shared types and constants for the magic-word length-prefixed frame receiver
package mlfr_pkg;

   localparam int LEN_W   = 25;
   localparam int IDLE_W  = 32;
   localparam int ALEN_W  = 32;
   localparam int HOLD_W  = 24;
   localparam int CSR_W   = 32;

   localparam logic [LEN_W-1:0]  EXPECTED_LENGTH_RESET = 25'd4096;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET      = 32'd5000;

   localparam logic [7:0]        MAGIC_FIRST = 8'h49;       // 'I'
   localparam logic [HOLD_W-1:0] MAGIC_REST  = 24'h4D4730;  // 'M','G','0'

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic CSR_EXPECTED_LENGTH = 1'b0;
   localparam logic CSR_IDLE_LIMIT      = 1'b1;

   localparam logic [1:0] STATUS_PAYLOAD  = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_MAGIC,
      PH_LEN,
      PH_DATA
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [HOLD_W-1:0]  magic_hold;
      logic [ALEN_W-1:0]  length_accum;
      logic [LEN_W-1:0]   byte_count;
      logic [IDLE_W-1:0]  idle_ticks;
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic [7:0]         payload_byte;
      logic               last;
      logic [ALEN_W-1:0]  announced_length;
   } result_type;

endpackage

// File: rtl/magic_length_frame_receiver_core.sv
// top level of the magic-word length-prefixed frame receiver
// latency: a result appears in the cycle after its request is accepted
// throughput: one request per cycle; the single result register gates acceptance
// reset: synchronous, active high; hunts for the first magic byte, clears the
// byte and idle counters, and loads expected_length 4096 and idle_limit_ms 5000
module magic_length_frame_receiver_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_last,
   output logic [mlfr_pkg::ALEN_W-1:0]   rsp_announced_length,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [mlfr_pkg::CSR_W-1:0]    csr_wdata
);
   import mlfr_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   result_type        result;
   logic [LEN_W-1:0]  expected_length_ff;
   logic [IDLE_W-1:0] idle_limit_ff;
   logic              slot_free;
   logic              accept;

   assign req_ready = slot_free;
   assign accept    = req_valid && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff <= EXPECTED_LENGTH_RESET;
         idle_limit_ff      <= IDLE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_LENGTH: expected_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_IDLE_LIMIT:      idle_limit_ff      <= csr_wdata[IDLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mlfr_step u_step (
      .state           (state_ff),
      .action          (req_action),
      .rx_byte         (req_rx_byte),
      .expected_length (expected_length_ff),
      .idle_limit_ms   (idle_limit_ff),
      .state_next      (state_in),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_HUNT;
         state_ff.magic_hold   <= '0;
         state_ff.length_accum <= '0;
         state_ff.byte_count   <= '0;
         state_ff.idle_ticks   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   mlfr_out_reg u_out (
      .clock                (clock),
      .reset                (reset),
      .load                 (accept),
      .result               (result),
      .slot_free            (slot_free),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_last             (rsp_last),
      .rsp_announced_length (rsp_announced_length)
   );

endmodule

// File: rtl/mlfr_step.sv
// next-state and result logic for one request
module mlfr_step (
   input  mlfr_pkg::state_type                 state,
   input  logic                                action,
   input  logic [7:0]                          rx_byte,
   input  logic [mlfr_pkg::LEN_W-1:0]          expected_length,
   input  logic [mlfr_pkg::IDLE_W-1:0]         idle_limit_ms,
   output mlfr_pkg::state_type                 state_next,
   output mlfr_pkg::result_type                result
);
   import mlfr_pkg::*;

   logic [IDLE_W-1:0] idle_inc;
   logic [LEN_W-1:0]  count_inc;
   logic [HOLD_W-1:0] hold_shift;
   logic [ALEN_W-1:0] accum_shift;

   assign idle_inc    = (state.idle_ticks == '1) ? state.idle_ticks : state.idle_ticks + 1'b1;
   assign count_inc   = state.byte_count + 1'b1;
   assign hold_shift  = {state.magic_hold[HOLD_W-9:0], rx_byte};
   assign accum_shift = {rx_byte, state.length_accum[ALEN_W-1:8]};

   always_comb begin
      state_next = state;
      result     = '0;
      if (action == ACTION_TICK) begin
         if (state.phase != PH_HUNT) begin
            state_next.idle_ticks = idle_inc;
            if (idle_inc > idle_limit_ms) begin
               state_next.phase      = PH_HUNT;
               state_next.byte_count = '0;
               state_next.idle_ticks = '0;
               result.valid          = 1'b1;
               result.status         = STATUS_TIMEOUT;
            end
         end
      end else begin
         case (state.phase)
            PH_HUNT: begin
               if (rx_byte == MAGIC_FIRST) begin
                  state_next.phase      = PH_MAGIC;
                  state_next.byte_count = '0;
                  state_next.idle_ticks = '0;
               end
            end
            PH_MAGIC: begin
               state_next.idle_ticks = '0;
               state_next.magic_hold = hold_shift;
               state_next.byte_count = count_inc;
               if (count_inc >= LEN_W'(3)) begin
                  state_next.byte_count = '0;
                  state_next.phase      = (hold_shift == MAGIC_REST) ? PH_LEN : PH_HUNT;
               end
            end
            PH_LEN: begin
               state_next.idle_ticks   = '0;
               state_next.length_accum = accum_shift;
               state_next.byte_count   = count_inc;
               if (count_inc >= LEN_W'(4)) begin
                  state_next.byte_count = '0;
                  if (accum_shift != {{(ALEN_W-LEN_W){1'b0}}, expected_length}) begin
                     state_next.phase        = PH_HUNT;
                     result.valid            = 1'b1;
                     result.status           = STATUS_BAD_LEN;
                     result.announced_length = accum_shift;
                  end else if (expected_length == '0) begin
                     state_next.phase = PH_HUNT;
                  end else begin
                     state_next.phase = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               state_next.idle_ticks = '0;
               state_next.byte_count = count_inc;
               result.valid          = 1'b1;
               result.status         = STATUS_PAYLOAD;
               result.payload_byte   = rx_byte;
               // count wrapping to zero also closes the frame
               if (count_inc >= expected_length || count_inc == '0) begin
                  state_next.phase      = PH_HUNT;
                  state_next.byte_count = '0;
                  result.last           = 1'b1;
               end
            end
            default: begin
               state_next.phase = PH_HUNT;
            end
         endcase
      end
   end

endmodule

// File: rtl/mlfr_out_reg.sv
// result register with valid/ready towards the consumer
module mlfr_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  mlfr_pkg::result_type          result,
   output logic                          slot_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_last,
   output logic [mlfr_pkg::ALEN_W-1:0]   rsp_announced_length
);
   import mlfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load && result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = data_ff.status;
   assign rsp_payload_byte     = data_ff.payload_byte;
   assign rsp_last             = data_ff.last;
   assign rsp_announced_length = data_ff.announced_length;

endmodule
